[hdl/hsc_pkg.sv]
// Package for the Hamming single-error-correcting codec.
// Holds the shared constants, the transaction kind and the result status codes.
// No dependencies.
package hsc_pkg;

    localparam int MAX_DATA_BITS   = 57;
    localparam int MAX_PARITY_BITS = 6;

    // Width and reset value of the data length register.
    localparam int            CFG_W     = 6;
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd4;

    typedef enum logic {
        KIND_ENCODE = 1'b0,
        KIND_DECODE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_CLEAN     = 2'd0,
        STATUS_CORRECTED = 2'd1,
        STATUS_BEYOND    = 2'd2
    } status_t;

endpackage

[hdl/hsc_cmd_if.sv]
// Command channel of the Hamming codec: valid/ready plus one input item.
// Depends on hsc_pkg.
interface hsc_cmd_if #(
    parameter int MAX_DATA_BITS   = hsc_pkg::MAX_DATA_BITS,
    parameter int MAX_PARITY_BITS = hsc_pkg::MAX_PARITY_BITS
);
    localparam int DATA_W = MAX_DATA_BITS;
    localparam int CW_W   = (1 << MAX_PARITY_BITS) - 1;

    logic                valid;
    logic                ready;
    hsc_pkg::kind_t      kind;
    logic [DATA_W-1:0]   data_word;
    logic [CW_W-1:0]     codeword_in;

    modport source (output valid, kind, data_word, codeword_in, input ready);
    modport sink   (input valid, kind, data_word, codeword_in, output ready);
endinterface

[hdl/hsc_rsp_if.sv]
// Response channel of the Hamming codec: valid/ready plus one result item.
// Depends on hsc_pkg.
interface hsc_rsp_if #(
    parameter int MAX_DATA_BITS   = hsc_pkg::MAX_DATA_BITS,
    parameter int MAX_PARITY_BITS = hsc_pkg::MAX_PARITY_BITS
);
    localparam int DATA_W = MAX_DATA_BITS;
    localparam int CW_W   = (1 << MAX_PARITY_BITS) - 1;
    localparam int SYN_W  = MAX_PARITY_BITS;

    logic                 valid;
    logic                 ready;
    logic [CW_W-1:0]      codeword_out;
    logic [DATA_W-1:0]    data_out;
    logic [SYN_W-1:0]     syndrome;
    hsc_pkg::status_t     status;

    modport source (output valid, codeword_out, data_out, syndrome, status, input ready);
    modport sink   (input valid, codeword_out, data_out, syndrome, status, output ready);
endinterface

[hdl/hsc_syndrome.sv]
// Syndrome unit: XOR of the 1-based positions of all set bits of a codeword.
// Purely combinational; no package dependency.
module hsc_syndrome #(
    parameter int SYN_W = 6
) (
    input  logic [(1 << SYN_W)-2:0] word,
    output logic [SYN_W-1:0]        syn
);

    localparam int CW_W = (1 << SYN_W) - 1;

    always_comb
    begin
        syn = '0;
        for (int p = 1; p <= CW_W; p++)
        begin
            if (word[p-1])
            begin
                syn = syn ^ SYN_W'(p);
            end
        end
    end

endmodule

[hdl/hamming_sec_codec.sv]
// Top level of the Hamming single-error-correcting codec, three register stages.
// Depends on hsc_pkg, hsc_cmd_if, hsc_rsp_if and hsc_syndrome.
//
//   port         | dir | handshake    | carries
//   -------------+-----+--------------+-------------------------------------------
//   cmd          | in  | valid/ready  | kind, data_word, codeword_in
//   rsp          | out | valid/ready  | codeword_out, data_out, syndrome, status
//   cfg_wr_en/.. | in  | write strobe | data_bits (6 bits), taken on the same edge
//
// A command passes stages one and two into the output register, where its response
// stays valid until taken; a transaction is accepted in every cycle while rsp is not
// stalled. Stage one masks and places the bits, stage two forms the syndrome, stage
// three inserts parity or corrects and extracts the data. A stalled rsp fills the
// stages and drops cmd.ready; reset empties them and sets data_bits to 4.
module hamming_sec_codec #(
    parameter int MAX_DATA_BITS   = hsc_pkg::MAX_DATA_BITS,
    parameter int MAX_PARITY_BITS = hsc_pkg::MAX_PARITY_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    hsc_cmd_if.sink                    cmd,
    hsc_rsp_if.source                  rsp,
    input  logic                       cfg_wr_en,
    input  logic [hsc_pkg::CFG_W-1:0]  cfg_wr_data
);

    localparam int DATA_W = MAX_DATA_BITS;
    localparam int SYN_W  = MAX_PARITY_BITS;
    localparam int CW_W   = (1 << SYN_W) - 1;
    localparam int NW     = $clog2(DATA_W + 1);
    localparam int RW     = $clog2(SYN_W + 1);
    localparam int LSW    = $clog2(DATA_W + SYN_W + 1);
    localparam int CMP_W  = SYN_W + LSW + 1;

    typedef struct packed {
        logic [SYN_W-1:0]  len;
        logic [DATA_W-1:0] n_mask;
        logic [CW_W-1:0]   l_mask;
    } cfg_t;

    // Turns the data length register value into codeword length and masks.
    function automatic cfg_t decode_cfg(input logic [hsc_pkg::CFG_W-1:0] value);
        cfg_t              c;
        logic [NW-1:0]     n;
        logic [RW-1:0]     r;
        logic [LSW-1:0]    sum;
        if (value == '0)
        begin
            n = NW'(1);
        end
        else if (value > hsc_pkg::CFG_W'(DATA_W))
        begin
            n = NW'(DATA_W);
        end
        else
        begin
            n = NW'(value);
        end
        r = '0;
        for (int i = 0; i < SYN_W; i++)
        begin
            if ((CMP_W'(1) << r) < (CMP_W'(n) + CMP_W'(r) + CMP_W'(1)))
            begin
                r = r + RW'(1);
            end
        end
        sum = LSW'(n) + LSW'(r);
        if (sum > LSW'(CW_W))
        begin
            sum = LSW'(CW_W);
        end
        c.len = SYN_W'(sum);
        for (int k = 0; k < DATA_W; k++)
        begin
            c.n_mask[k] = (NW'(k) < n);
        end
        for (int p = 1; p <= CW_W; p++)
        begin
            c.l_mask[p-1] = (SYN_W'(p) <= c.len);
        end
        return c;
    endfunction

    // Data bit k goes to the k-th position that is not a power of two.
    function automatic logic [CW_W-1:0] spread(input logic [DATA_W-1:0] d);
        logic [CW_W-1:0] w;
        int              k;
        w = '0;
        k = 0;
        for (int p = 1; p <= CW_W; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                if (k < DATA_W)
                begin
                    w[p-1] = d[k];
                end
                k++;
            end
        end
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] extract(input logic [CW_W-1:0] w);
        logic [DATA_W-1:0] d;
        int                k;
        d = '0;
        k = 0;
        for (int p = 1; p <= CW_W; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                if (k < DATA_W)
                begin
                    d[k] = w[p-1];
                end
                k++;
            end
        end
        return d;
    endfunction

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= decode_cfg(hsc_pkg::CFG_RESET);
        end
        else if (cfg_wr_en)
        begin
            cfg_reg <= decode_cfg(cfg_wr_data);
        end
    end

    // Pipeline flow control: a stage loads when it is empty or the next one moves.
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic adv1, adv2, adv3;

    assign adv3      = rsp.ready || !out_valid_reg;
    assign adv2      = adv3 || !s2_valid_reg;
    assign adv1      = adv2 || !s1_valid_reg;
    assign cmd.ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= cmd.valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage one: masked word with the data placed, or the received word.
    hsc_pkg::kind_t   s1_kind_reg;
    logic [CW_W-1:0]  s1_word_reg, s1_word_next;

    always_comb
    begin
        if (cmd.kind == hsc_pkg::KIND_ENCODE)
        begin
            s1_word_next = spread(cmd.data_word & cfg_reg.n_mask);
        end
        else
        begin
            s1_word_next = cmd.codeword_in & cfg_reg.l_mask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_kind_reg <= cmd.kind;
            s1_word_reg <= s1_word_next;
        end
    end

    // Stage two: syndrome of the stage one word.
    hsc_pkg::kind_t   s2_kind_reg;
    logic [CW_W-1:0]  s2_word_reg;
    logic [SYN_W-1:0] s2_syn_reg, s2_syn_next;

    hsc_syndrome #(
        .SYN_W (SYN_W)
    ) u_syndrome (
        .word (s1_word_reg),
        .syn  (s2_syn_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_word_reg <= s1_word_reg;
            s2_syn_reg  <= s2_syn_next;
        end
    end

    // Stage three: parity insertion on encode, correction on decode.
    logic [CW_W-1:0]   flip, par, cw_next, cw_out_reg;
    logic [DATA_W-1:0] dout_out_reg;
    logic [SYN_W-1:0]  syn_next, syn_out_reg;
    hsc_pkg::status_t  status_next, status_out_reg;

    always_comb
    begin
        flip = '0;
        par  = '0;
        for (int p = 1; p <= CW_W; p++)
        begin
            flip[p-1] = (s2_syn_reg == SYN_W'(p));
        end
        for (int i = 0; i < SYN_W; i++)
        begin
            par[(1 << i) - 1] = s2_syn_reg[i];
        end
        cw_next     = s2_word_reg;
        syn_next    = s2_syn_reg;
        status_next = hsc_pkg::STATUS_CLEAN;
        if (s2_kind_reg == hsc_pkg::KIND_ENCODE)
        begin
            cw_next  = s2_word_reg | par;
            syn_next = '0;
        end
        else if (s2_syn_reg != '0)
        begin
            if (s2_syn_reg <= cfg_reg.len)
            begin
                cw_next     = s2_word_reg ^ flip;
                status_next = hsc_pkg::STATUS_CORRECTED;
            end
            else
            begin
                status_next = hsc_pkg::STATUS_BEYOND;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            cw_out_reg     <= cw_next;
            dout_out_reg   <= extract(cw_next) & cfg_reg.n_mask;
            syn_out_reg    <= syn_next;
            status_out_reg <= status_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.codeword_out = cw_out_reg;
    assign rsp.data_out     = dout_out_reg;
    assign rsp.syndrome     = syn_out_reg;
    assign rsp.status       = status_out_reg;

endmodule

[hdl/hsc_checker.sv]
// Port-level assertions for hamming_sec_codec, attached with a bind statement.
// Depends on hsc_pkg and the hamming_sec_codec top level.
module hsc_checker #(
    parameter int DATA_W = hsc_pkg::MAX_DATA_BITS,
    parameter int SYN_W  = hsc_pkg::MAX_PARITY_BITS
) (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     cmd_valid,
    input logic                     cmd_ready,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic [(1 << SYN_W)-2:0]  rsp_codeword_out,
    input logic [DATA_W-1:0]        rsp_data_out,
    input logic [SYN_W-1:0]         rsp_syndrome,
    input logic [1:0]               rsp_status
);

    localparam logic [2:0] PIPE_DEPTH = 3'd3;

    // Transactions accepted on cmd and not yet delivered on rsp.
    logic [2:0] occ_reg, occ_next;
    logic       in_acc, out_acc;

    assign in_acc  = cmd_valid && cmd_ready;
    assign out_acc = rsp_valid && rsp_ready;

    always_comb
    begin
        occ_next = occ_reg + {2'b00, in_acc} - {2'b00, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_codeword_out)
            && $stable(rsp_data_out) && $stable(rsp_syndrome) && $stable(rsp_status))
        else $error("response changed while stalled");

    a_clean_zero_syn: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_status == hsc_pkg::STATUS_CLEAN) == (rsp_syndrome == '0)))
        else $error("status and syndrome disagree");

    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_ready || !rsp_valid) |-> cmd_ready)
        else $error("cmd stalled while the output can move");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= PIPE_DEPTH)
        else $error("more transactions in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> occ_reg != '0)
        else $error("response without an outstanding command");

endmodule

bind hamming_sec_codec hsc_checker #(
    .DATA_W (DATA_W),
    .SYN_W  (SYN_W)
) u_hsc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd.valid),
    .cmd_ready        (cmd.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_codeword_out (rsp.codeword_out),
    .rsp_data_out     (rsp.data_out),
    .rsp_syndrome     (rsp.syndrome),
    .rsp_status       (rsp.status)
);
